/* sv/ahtd_pkg.sv */
// types and constants shared by the ascii hex tlv deframer modules
`default_nettype none

package ahtd_pkg;

    // frame layout
    localparam int unsigned TYPE_BYTES   = 4;
    localparam int unsigned HEADER_BYTES = 8;
    localparam int unsigned COUNT_W      = 4;

    // result kinds
    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    // one item of the byte stream
    typedef struct packed {
        logic [7:0] in_byte;
        logic       chunk_last;
    } in_item_t;

    // one result item
    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  out_byte;
        logic [31:0] msg_type;
        logic [15:0] msg_length;
        logic        msg_last;
    } out_item_t;

    // classified byte passed from front to back
    typedef struct packed {
        logic [7:0] data;
        logic [3:0] digit;
        logic       is_digit;
        logic       is_ws;
    } tok_t;

endpackage

`default_nettype wire

/* sv/ascii_hex_tlv_deframer_unit.sv */
// top level of the ascii hex type-length-value deframer
// each accepted byte is held in the queue, then parsed, and any result is registered
// throughput: one byte per cycle unless stalled; the two-entry queue and the
// result register let front end and parser stall independently
// reset: rst_n clears all header, payload and handshake state at once
`default_nettype none

module ascii_hex_tlv_deframer_unit
    import ahtd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      byte_valid,
    output logic           byte_ready,
    input  wire in_item_t  byte_item,
    output logic           result_valid,
    input  wire logic      result_ready,
    output out_item_t      result
);

    logic push;
    tok_t push_tok;
    logic full;
    logic pop;
    logic head_valid;
    tok_t head_tok;

    // byte classification
    ahtd_classify u_classify (
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item),
        .push       (push),
        .tok        (push_tok),
        .full       (full)
    );

    // decoupling queue
    ahtd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_tok   (push_tok),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_tok   (head_tok)
    );

    // frame parser and result register
    ahtd_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_tok     (head_tok),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire

/* sv/ahtd_classify.sv */
// front end: accepts stream items and classifies each byte for the length parser
`default_nettype none

module ahtd_classify
    import ahtd_pkg::*;
(
    input  wire logic     byte_valid,
    output logic          byte_ready,
    input  wire in_item_t byte_item,
    output logic          push,
    output tok_t          tok,
    input  wire logic     full
);

    logic [7:0] b;

    // take an item whenever the queue has room
    assign byte_ready = !full;
    assign push       = byte_valid && !full;
    assign b          = byte_item.in_byte;

    // hex digit and whitespace decode
    always_comb
    begin
        tok.data     = b;
        tok.digit    = 4'd0;
        tok.is_digit = 1'b0;
        tok.is_ws    = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
        if (b >= 8'h30 && b <= 8'h39)
        begin
            tok.digit    = 4'(b - 8'h30);
            tok.is_digit = 1'b1;
        end
        else if (b >= 8'h61 && b <= 8'h66)
        begin
            tok.digit    = 4'(b - 8'h57);
            tok.is_digit = 1'b1;
        end
        else if (b >= 8'h41 && b <= 8'h46)
        begin
            tok.digit    = 4'(b - 8'h37);
            tok.is_digit = 1'b1;
        end
    end

endmodule

`default_nettype wire

/* sv/ahtd_queue.sv */
// two-entry queue of classified bytes between front end and parser
`default_nettype none

module ahtd_queue
    import ahtd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire tok_t push_tok,
    output logic      full,
    input  wire logic pop,
    output logic      head_valid,
    output tok_t      head_tok
);

    tok_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_tok   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (do_push && !do_pop)
                count_reg <= count_reg + 2'd1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 2'd1;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_tok;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

endmodule

`default_nettype wire

/* sv/ahtd_parser.sv */
// back end: header and length parsing, payload pass-through, result register
`default_nettype none

module ahtd_parser
    import ahtd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic head_valid,
    input  wire tok_t head_tok,
    output logic      pop,
    output logic      result_valid,
    input  wire logic result_ready,
    output out_item_t result
);

    typedef enum logic [1:0] {
        PH_LEAD   = 2'd0,
        PH_DIGITS = 2'd1,
        PH_TRAIL  = 2'd2
    } phase_t;

    localparam logic [COUNT_W-1:0] TYPE_CNT = COUNT_W'(TYPE_BYTES);
    localparam logic [COUNT_W-1:0] HDR_CNT  = COUNT_W'(HEADER_BYTES);

    logic [COUNT_W-1:0] header_count_reg, header_count_next;
    logic [31:0]        type_reg, type_next;
    logic [15:0]        length_accum_reg, length_accum_next;
    phase_t             phase_reg, phase_next;
    logic               hex_error_reg, hex_error_next;
    logic [15:0]        payload_remaining_reg, payload_remaining_next;
    logic               in_payload_reg, in_payload_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_reg, out_next;

    logic               step;
    logic               emit;
    out_item_t          emit_item;
    logic [15:0]        rem_dec;
    logic               clear;

    // a byte is taken when the result slot is free or draining
    assign step         = head_valid && (!out_valid_reg || result_ready);
    assign pop          = step;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign rem_dec      = payload_remaining_reg - 16'd1;

    // per-byte parse step
    always_comb
    begin
        header_count_next      = header_count_reg;
        type_next              = type_reg;
        length_accum_next      = length_accum_reg;
        phase_next             = phase_reg;
        hex_error_next         = hex_error_reg;
        payload_remaining_next = payload_remaining_reg;
        in_payload_next        = in_payload_reg;
        emit                   = 1'b0;
        clear                  = 1'b0;
        emit_item.result_kind  = KIND_PAYLOAD;
        emit_item.out_byte     = 8'd0;
        emit_item.msg_type     = type_reg;
        emit_item.msg_length   = 16'd0;
        emit_item.msg_last     = 1'b1;

        if (step)
        begin
            if (in_payload_reg)
            begin
                // payload pass-through
                payload_remaining_next = rem_dec;
                emit                   = 1'b1;
                emit_item.result_kind  = KIND_PAYLOAD;
                emit_item.out_byte     = head_tok.data;
                emit_item.msg_length   = length_accum_reg;
                emit_item.msg_last     = (rem_dec == 16'd0);
                if (rem_dec == 16'd0)
                begin
                    in_payload_next = 1'b0;
                    clear           = 1'b1;
                end
            end
            else if (header_count_reg < TYPE_CNT)
            begin
                // type byte
                type_next         = {type_reg[23:0], head_tok.data};
                header_count_next = header_count_reg + COUNT_W'(1);
            end
            else
            begin
                // length field character
                unique case (phase_reg)
                    PH_LEAD:
                    begin
                        if (head_tok.is_digit)
                        begin
                            length_accum_next = {12'd0, head_tok.digit};
                            phase_next        = PH_DIGITS;
                        end
                        else if (!head_tok.is_ws)
                            hex_error_next = 1'b1;
                    end
                    PH_DIGITS:
                    begin
                        if (head_tok.is_digit)
                            length_accum_next = {length_accum_reg[11:0], head_tok.digit};
                        else if (head_tok.is_ws)
                            phase_next = PH_TRAIL;
                        else
                            hex_error_next = 1'b1;
                    end
                    PH_TRAIL:
                    begin
                        if (!head_tok.is_ws)
                            hex_error_next = 1'b1;
                    end
                    default:
                        hex_error_next = 1'b1;
                endcase
                header_count_next = header_count_reg + COUNT_W'(1);

                // end of header
                if (header_count_next == HDR_CNT)
                begin
                    if (hex_error_next || phase_next == PH_LEAD)
                    begin
                        emit                  = 1'b1;
                        emit_item.result_kind = KIND_ERROR;
                        clear                 = 1'b1;
                    end
                    else if (length_accum_next == 16'd0)
                    begin
                        emit                  = 1'b1;
                        emit_item.result_kind = KIND_EMPTY;
                        clear                 = 1'b1;
                    end
                    else
                    begin
                        payload_remaining_next = length_accum_next;
                        in_payload_next        = 1'b1;
                    end
                end
            end
        end

        if (clear)
        begin
            header_count_next = '0;
            type_next         = 32'd0;
            length_accum_next = 16'd0;
            phase_next        = PH_LEAD;
            hex_error_next    = 1'b0;
        end

        // result slot
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_next       = emit_item;
        end
        else
        begin
            out_valid_next = out_valid_reg && !result_ready;
            out_next       = out_reg;
        end
    end

    // parser state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_count_reg      <= '0;
            type_reg              <= 32'd0;
            length_accum_reg      <= 16'd0;
            phase_reg             <= PH_LEAD;
            hex_error_reg         <= 1'b0;
            payload_remaining_reg <= 16'd0;
            in_payload_reg        <= 1'b0;
            out_valid_reg         <= 1'b0;
            out_reg               <= '0;
        end
        else
        begin
            header_count_reg      <= header_count_next;
            type_reg              <= type_next;
            length_accum_reg      <= length_accum_next;
            phase_reg             <= phase_next;
            hex_error_reg         <= hex_error_next;
            payload_remaining_reg <= payload_remaining_next;
            in_payload_reg        <= in_payload_next;
            out_valid_reg         <= out_valid_next;
            out_reg               <= out_next;
        end
    end

    a_payload_after_header: assert property (@(posedge clk) disable iff (!rst_n)
        in_payload_reg |-> (header_count_reg == HDR_CNT && payload_remaining_reg != 16'd0))
        else $error("payload phase without complete header");

    a_header_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        header_count_reg <= HDR_CNT)
        else $error("header count overran");

    a_nonpayload_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.result_kind != KIND_PAYLOAD)
            |-> (out_reg.msg_last && out_reg.msg_length == 16'd0 && out_reg.out_byte == 8'd0))
        else $error("empty or error result malformed");

    a_no_step_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result_ready) |-> !pop)
        else $error("byte consumed while result slot blocked");

endmodule

`default_nettype wire

/* sim/ascii_hex_tlv_deframer_unit_tb.sv */
// self-checking testbench for the ascii hex tlv deframer: directed and random byte streams
module ascii_hex_tlv_deframer_unit_tb
    import ahtd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned HALF_PERIOD  = 10;
    localparam int unsigned RESET_CYCLES = 9;
    localparam int unsigned RANDOM_BYTES = 1800;
    localparam int unsigned TAIL_CYCLES  = 8;
    localparam int unsigned CYCLE_LIMIT  = 1000000;

    // phases of the length field parse
    typedef enum logic [1:0] {
        LEN_LEAD   = 2'd0,
        LEN_DIGITS = 2'd1,
        LEN_TRAIL  = 2'd2
    } len_phase_t;

    // bytes outside the hex digit and whitespace classes, most just beside their bounds
    logic [7:0] odd_chars [16] = '{8'h2f, 8'h3a, 8'h40, 8'h47, 8'h60, 8'h67, 8'h2b, 8'h2d,
                                   8'h78, 8'h58, 8'h08, 8'h0e, 8'h1f, 8'h21, 8'h00, 8'hff};

    // tracks frame state and holds the results each accepted byte should produce
    class tlv_frame_checker;
        out_item_t   expected_results[$];
        int unsigned errors;
        logic [3:0]  hdr_taken;
        logic [31:0] type_word;
        logic [15:0] len_value;
        len_phase_t  len_phase;
        bit          len_bad;
        logic [15:0] bytes_left;
        bit          in_body;

        function new();
            errors     = 0;
            bytes_left = '0;
            in_body    = 0;
            clear_header();
        endfunction

        function void clear_header();
            hdr_taken = '0;
            type_word = '0;
            len_value = '0;
            len_phase = LEN_LEAD;
            len_bad   = 0;
        endfunction

        function void push_result(kind_t kind, logic [7:0] data, logic [15:0] len, bit last);
            out_item_t r;
            r.result_kind = kind;
            r.out_byte    = data;
            r.msg_type    = type_word;
            r.msg_length  = len;
            r.msg_last    = last;
            expected_results.push_back(r);
        endfunction

        function void take_byte(in_item_t it);
            logic [7:0] b;
            logic [3:0] digit;
            bit         is_hex;
            bit         is_ws;
            b = it.in_byte;

            // payload passes straight through
            if (in_body) begin
                bytes_left = bytes_left - 16'd1;
                push_result(KIND_PAYLOAD, b, len_value, bytes_left == 16'd0);
                if (bytes_left == 16'd0) begin
                    in_body = 0;
                    clear_header();
                end
                return;
            end

            // type bytes, first one ends up on top
            if (hdr_taken < TYPE_BYTES) begin
                type_word = {type_word[23:0], b};
                hdr_taken = hdr_taken + 4'd1;
                return;
            end

            // classify one length character
            is_ws  = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0d);
            is_hex = 1;
            if (b >= 8'h30 && b <= 8'h39)
                digit = 4'(b - 8'h30);
            else if (b >= 8'h61 && b <= 8'h66)
                digit = 4'(b - 8'h61 + 8'd10);
            else if (b >= 8'h41 && b <= 8'h46)
                digit = 4'(b - 8'h41 + 8'd10);
            else begin
                digit  = '0;
                is_hex = 0;
            end

            case (len_phase)
                LEN_LEAD:
                begin
                    if (is_hex) begin
                        len_value = {12'd0, digit};
                        len_phase = LEN_DIGITS;
                    end else if (!is_ws)
                        len_bad = 1;
                end
                LEN_DIGITS:
                begin
                    if (is_hex)
                        len_value = {len_value[11:0], digit};
                    else if (is_ws)
                        len_phase = LEN_TRAIL;
                    else
                        len_bad = 1;
                end
                LEN_TRAIL:
                begin
                    if (!is_ws)
                        len_bad = 1;
                end
                default:
                begin
                    len_bad = 1;
                end
            endcase
            hdr_taken = hdr_taken + 4'd1;

            if (hdr_taken < HEADER_BYTES)
                return;

            // header complete: error, empty frame or start of payload
            if (len_bad || len_phase == LEN_LEAD) begin
                push_result(KIND_ERROR, 8'h00, 16'd0, 1);
                clear_header();
            end else if (len_value == 16'd0) begin
                push_result(KIND_EMPTY, 8'h00, 16'd0, 1);
                clear_header();
            end else begin
                bytes_left = len_value;
                in_body    = 1;
            end
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s expected %0h actual %0h", $realtime, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_results.size() == 0) begin
                $display({"%0t: unexpected result, expected none, actual kind %0d byte %02h",
                          " type %08h length %0d last %0b"},
                         $realtime, got.result_kind, got.out_byte, got.msg_type,
                         got.msg_length, got.msg_last);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("result_kind", 32'(want.result_kind), 32'(got.result_kind));
            compare_field("out_byte", 32'(want.out_byte), 32'(got.out_byte));
            compare_field("msg_type", want.msg_type, got.msg_type);
            compare_field("msg_length", 32'(want.msg_length), 32'(got.msg_length));
            compare_field("msg_last", 32'(want.msg_last), 32'(got.msg_last));
        endfunction
    endclass

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        byte_valid   = 1'b0;
    in_item_t    byte_item    = '0;
    logic        result_ready = 1'b0;
    logic        byte_ready;
    logic        result_valid;
    out_item_t   result;

    tlv_frame_checker frames;
    bit               steady     = 0;
    int unsigned      ready_hold = 0;
    int unsigned      sent_count = 0;
    int unsigned      cycles     = 0;

    ascii_hex_tlv_deframer_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .byte_item    (byte_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // clock
    always #(HALF_PERIOD) clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("ascii_hex_tlv_deframer_unit_tb: errors");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side stalls
    always @(posedge clk)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else if (ready_hold != 0) begin
            ready_hold = ready_hold - 1;
            result_ready <= 1'b0;
        end else if (!steady && $urandom_range(0, 99) < 25) begin
            ready_hold = pick_gap() - 1;
            result_ready <= 1'b0;
        end else
            result_ready <= 1'b1;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            frames.check_result(result);
    end

    // drive one byte, wait for it to be taken, then maybe idle
    task automatic send_byte(input logic [7:0] b);
        in_item_t    it;
        int unsigned gap;
        it.in_byte    = b;
        it.chunk_last = 1'($urandom_range(0, 1));
        byte_item  <= it;
        byte_valid <= 1'b1;
        do @(posedge clk); while (!byte_ready);
        frames.take_byte(it);
        sent_count++;
        gap = (!steady && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
        if (gap != 0) begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_type(input logic [31:0] t);
        for (int i = 3; i >= 0; i--)
            send_byte(t[8*i +: 8]);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // finish any open frame with random payload
    task automatic send_payload();
        while (frames.in_body)
            send_byte(8'($urandom_range(0, 255)));
    endtask

    // hold the sender until every expected result is in
    task automatic wait_results_done();
        byte_valid <= 1'b0;
        do @(posedge clk); while (frames.expected_results.size() != 0);
    endtask

    function automatic logic [7:0] ws_char();
        int unsigned r;
        r = $urandom_range(0, 5);
        if (r == 0)
            return 8'h20;
        return 8'h08 + 8'(r);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10)
            return 8'h30 + 8'(v);
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(v) - 8'd10;
    endfunction

    // one frame: mostly well formed, some broken length fields and noise
    task automatic random_frame();
        logic [7:0]  len_field [4];
        int unsigned sel;
        int unsigned r;
        int unsigned len;
        int unsigned ndig;
        int unsigned lead;
        sel = $urandom_range(0, 99);
        r   = $urandom_range(0, 99);
        if (r < 10)
            len = 0;
        else if (r < 88)
            len = $urandom_range(1, 24);
        else
            len = $urandom_range(25, 300);
        ndig = (len < 16) ? 1 : (len < 256) ? 2 : 3;
        ndig = $urandom_range(ndig, 4);
        lead = $urandom_range(0, 4 - ndig);
        for (int i = 0; i < 4; i++)
            len_field[i] = ws_char();
        for (int i = 0; i < ndig; i++)
            len_field[lead + i] = hex_char(4'(len >> (4 * (ndig - 1 - i))));

        if (sel < 8) begin
            for (int i = 0; i < 4; i++)
                len_field[i] = 8'($urandom_range(0, 255));
        end else if (sel < 16)
            len_field[$urandom_range(0, 3)] = odd_chars[$urandom_range(0, 15)];
        else if (sel < 21) begin
            for (int i = 0; i < 4; i++)
                len_field[i] = ws_char();
        end else if (sel < 27) begin
            len_field[0] = hex_char(4'($urandom_range(0, 15)));
            len_field[1] = ws_char();
            len_field[2] = hex_char(4'($urandom_range(0, 15)));
            len_field[3] = $urandom_range(0, 1) ? ws_char() : hex_char(4'($urandom_range(0, 15)));
        end

        send_type($urandom());
        for (int i = 0; i < 4; i++)
            send_byte(len_field[i]);
        send_payload();
    endtask

    // main sequence
    initial
    begin
        int unsigned start_count;
        frames = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // short frame with extreme payload bytes
        send_type(32'h00ff_7f80);
        send_text("0003");
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(8'h41);
        // zero length
        send_type(32'hffff_ffff);
        send_text(" 0  ");
        // no digits at all
        send_type("ABCD");
        send_text("    ");
        // whitespace between digits
        send_type(32'h0000_0000);
        send_text("1 2 ");
        // sign and hex prefix are rejected
        send_type("typ1");
        send_text("+001");
        send_type("typ2");
        send_text("0x10");
        // every whitespace code around the digits
        send_type("tabs");
        send_text("\t1\015\n");
        send_payload();
        send_type("vtab");
        send_text(" a\013 ");
        send_payload();
        send_type("ffed");
        send_text("0E\014 ");
        send_payload();
        // bytes just outside the whitespace and hex digit ranges
        send_type("bnd0");
        send_text("9\010  ");
        send_type("bnd1");
        send_text("9\016  ");
        send_type("bnd2");
        send_text("g001");
        wait_results_done();

        // random frames
        start_count = sent_count;
        while (sent_count - start_count < RANDOM_BYTES) begin
            steady = ($urandom_range(0, 99) < 15);
            random_frame();
            if ($urandom_range(0, 99) < 5)
                wait_results_done();
        end
        steady = 0;

        wait_results_done();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (frames.errors == 0)
            $display("ascii_hex_tlv_deframer_unit_tb: clean");
        else
            $display("ascii_hex_tlv_deframer_unit_tb: errors");
        $finish;
    end

endmodule
